### design/est_pkg.sv
// ----------------------------------------------------------------------------
// est_pkg
// Shared types and constants for the event subscription table.
// ----------------------------------------------------------------------------
package est_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    typedef enum logic [1:0] {
        KIND_SUB   = 2'd0,
        KIND_UNSUB = 2'd1,
        KIND_PUB   = 2'd2,
        KIND_RSVD  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DISPATCH = 3'd5,
        ST_NOSUBS   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [15:0] event_id;
        logic [31:0] handler;
        logic [31:0] user;
        logic        has_user;
        logic        one_shot;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

### design/est_slot_mem.sv
// ----------------------------------------------------------------------------
// est_slot_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module est_slot_mem #(
    parameter int SLOTS = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  est_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  est_pkg::t_entry   i_wr_data,
    output est_pkg::t_entry   o_rd_data
);

    est_pkg::t_entry mem [SLOTS];
    est_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/est_ctrl.sv
// ----------------------------------------------------------------------------
// est_ctrl
// Sequencer: scans the slot memory, keeps valid bits, holds the result register.
// ----------------------------------------------------------------------------
module est_ctrl #(
    parameter int SLOTS = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [15:0]       i_event_id,
    input  logic [31:0]       i_handler_tag,
    input  logic [31:0]       i_user_tag,
    input  logic              i_has_user,
    input  logic              i_one_shot,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [4:0]        o_slot_index,
    output logic [31:0]       o_out_handler,
    output logic [31:0]       o_out_user,
    output logic              o_out_has_user,
    output logic              o_last,
    output est_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_rd_addr,
    output logic [AW-1:0]     o_wr_addr,
    output est_pkg::t_entry   o_wr_data,
    input  est_pkg::t_entry   i_rd_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    est_pkg::t_state r_state, n_state;

    logic [SLOTS-1:0]          r_valid, n_valid;
    logic                      r_iss, n_iss;
    logic [AW-1:0]             r_addr, n_addr;
    logic                      r_chk_vld, n_chk_vld;
    logic [AW-1:0]             r_chk_idx, n_chk_idx;
    logic                      r_free_fnd, n_free_fnd;
    logic [AW-1:0]             r_free, n_free;
    logic [est_pkg::CNT_W-1:0] r_cnt, n_cnt;

    est_pkg::t_kind            r_kind, n_kind;
    logic [15:0]               r_ev, n_ev;
    logic [31:0]               r_h, n_h;
    logic [31:0]               r_u, n_u;
    logic                      r_hu, n_hu;
    logic                      r_os, n_os;

    logic                      r_p_vld, n_p_vld;
    logic [4:0]                r_p_idx, n_p_idx;
    logic [31:0]               r_p_h, n_p_h;
    logic [31:0]               r_p_u, n_p_u;
    logic                      r_p_hu, n_p_hu;

    logic                      r_o_valid, n_o_valid;
    est_pkg::t_status          r_o_status, n_o_status;
    logic [4:0]                r_o_idx, n_o_idx;
    logic [31:0]               r_o_h, n_o_h;
    logic [31:0]               r_o_u, n_o_u;
    logic                      r_o_hu, n_o_hu;
    logic                      r_o_last, n_o_last;

    logic                      out_free;
    logic                      ev_hit;
    logic                      ex_hit;
    logic                      last_chk;
    logic [4:0]                chk_idx5;
    logic [4:0]                free_idx5;
    logic [AW+4:0]             chk_ext;
    logic [AW+4:0]             free_ext;
    logic [est_pkg::CNT_W-1:0] cnt_inc;

    assign out_free  = !r_o_valid || i_ready;
    assign ev_hit    = r_valid[r_chk_idx] && (i_rd_data.event_id == r_ev);
    assign ex_hit    = ev_hit && (i_rd_data.handler == r_h)
                       && (i_rd_data.has_user == r_hu) && (i_rd_data.user == r_u);
    assign last_chk  = (r_chk_idx == LAST_IDX);
    assign chk_ext   = {5'd0, r_chk_idx};
    assign free_ext  = {5'd0, r_free};
    assign chk_idx5  = chk_ext[4:0];
    assign free_idx5 = free_ext[4:0];
    assign cnt_inc   = r_cnt + est_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= est_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_iss      <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_cnt      <= '0;
            r_p_vld    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_iss      <= n_iss;
            r_chk_vld  <= n_chk_vld;
            r_free_fnd <= n_free_fnd;
            r_cnt      <= n_cnt;
            r_p_vld    <= n_p_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_chk_idx  <= n_chk_idx;
        r_free     <= n_free;
        r_kind     <= n_kind;
        r_ev       <= n_ev;
        r_h        <= n_h;
        r_u        <= n_u;
        r_hu       <= n_hu;
        r_os       <= n_os;
        r_p_idx    <= n_p_idx;
        r_p_h      <= n_p_h;
        r_p_u      <= n_p_u;
        r_p_hu     <= n_p_hu;
        r_o_status <= n_o_status;
        r_o_idx    <= n_o_idx;
        r_o_h      <= n_o_h;
        r_o_u      <= n_o_u;
        r_o_hu     <= n_o_hu;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_iss      = r_iss;
        n_addr     = r_addr;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_free_fnd = r_free_fnd;
        n_free     = r_free;
        n_cnt      = r_cnt;
        n_kind     = r_kind;
        n_ev       = r_ev;
        n_h        = r_h;
        n_u        = r_u;
        n_hu       = r_hu;
        n_os       = r_os;
        n_p_vld    = r_p_vld;
        n_p_idx    = r_p_idx;
        n_p_h      = r_p_h;
        n_p_u      = r_p_u;
        n_p_hu     = r_p_hu;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_idx    = r_o_idx;
        n_o_h      = r_o_h;
        n_o_u      = r_o_u;
        n_o_hu     = r_o_hu;
        n_o_last   = r_o_last;
        o_mem_ctl  = '0;
        o_rd_addr  = r_addr;
        o_wr_addr  = r_free;
        o_wr_data  = '{event_id: r_ev, handler: r_h, user: r_u,
                       has_user: r_hu, one_shot: r_os};
        o_ready    = (r_state == est_pkg::S_IDLE);

        unique case (r_state)
            est_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_kind     = est_pkg::t_kind'(i_kind);
                    n_ev       = i_event_id;
                    n_h        = i_handler_tag;
                    n_u        = i_has_user ? i_user_tag : 32'd0;
                    n_hu       = i_has_user;
                    n_os       = i_one_shot;
                    n_addr     = '0;
                    n_iss      = 1'b1;
                    n_chk_vld  = 1'b0;
                    n_free_fnd = 1'b0;
                    n_cnt      = '0;
                    n_p_vld    = 1'b0;
                    if (est_pkg::t_kind'(i_kind) != est_pkg::KIND_RSVD) begin
                        n_state = est_pkg::S_SCAN;
                    end
                end
            end
            est_pkg::S_SCAN: begin
                if (out_free) begin
                    n_chk_vld = r_iss;
                    if (r_iss) begin
                        o_mem_ctl.rd_en = 1'b1;
                        n_chk_idx       = r_addr;
                        n_addr          = r_addr + AW'(1);
                        n_iss           = (r_addr != LAST_IDX);
                    end
                    if (r_chk_vld) begin
                        priority case (r_kind)
                            est_pkg::KIND_SUB: begin
                                if (ex_hit) begin
                                    n_o_valid  = 1'b1;
                                    n_o_status = est_pkg::ST_DUP;
                                    n_o_idx    = chk_idx5;
                                    n_o_h      = '0;
                                    n_o_u      = '0;
                                    n_o_hu     = 1'b0;
                                    n_o_last   = 1'b1;
                                    n_state    = est_pkg::S_IDLE;
                                end else begin
                                    if (!r_valid[r_chk_idx] && !r_free_fnd) begin
                                        n_free_fnd = 1'b1;
                                        n_free     = r_chk_idx;
                                    end
                                    if (last_chk) begin
                                        n_state = est_pkg::S_FIN;
                                    end
                                end
                            end
                            est_pkg::KIND_UNSUB: begin
                                if (ex_hit) begin
                                    n_valid[r_chk_idx] = 1'b0;
                                    n_o_valid  = 1'b1;
                                    n_o_status = est_pkg::ST_REMOVED;
                                    n_o_idx    = chk_idx5;
                                    n_o_h      = '0;
                                    n_o_u      = '0;
                                    n_o_hu     = 1'b0;
                                    n_o_last   = 1'b1;
                                    n_state    = est_pkg::S_IDLE;
                                end else if (last_chk) begin
                                    n_state = est_pkg::S_FIN;
                                end
                            end
                            default: begin
                                if (ev_hit) begin
                                    if (r_p_vld) begin
                                        n_o_valid  = 1'b1;
                                        n_o_status = est_pkg::ST_DISPATCH;
                                        n_o_idx    = r_p_idx;
                                        n_o_h      = r_p_h;
                                        n_o_u      = r_p_u;
                                        n_o_hu     = r_p_hu;
                                        n_o_last   = 1'b0;
                                    end
                                    n_p_vld = 1'b1;
                                    n_p_idx = chk_idx5;
                                    n_p_h   = i_rd_data.handler;
                                    n_p_u   = i_rd_data.user;
                                    n_p_hu  = i_rd_data.has_user;
                                    n_cnt   = cnt_inc;
                                    if (i_rd_data.has_user && i_rd_data.one_shot) begin
                                        n_valid[r_chk_idx] = 1'b0;
                                    end
                                    if (last_chk
                                        || cnt_inc == est_pkg::CNT_W'(est_pkg::MAX_RESULTS)) begin
                                        n_state = est_pkg::S_FIN;
                                    end
                                end else if (last_chk) begin
                                    n_state = est_pkg::S_FIN;
                                end
                            end
                        endcase
                    end
                end
            end
            est_pkg::S_FIN: begin
                if (out_free) begin
                    n_state   = est_pkg::S_IDLE;
                    n_o_valid = 1'b1;
                    n_o_idx   = '0;
                    n_o_h     = '0;
                    n_o_u     = '0;
                    n_o_hu    = 1'b0;
                    n_o_last  = 1'b1;
                    priority case (r_kind)
                        est_pkg::KIND_SUB: begin
                            if (r_free_fnd) begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_valid[r_free] = 1'b1;
                                n_o_status      = est_pkg::ST_ADDED;
                                n_o_idx         = free_idx5;
                            end else begin
                                n_o_status = est_pkg::ST_FULL;
                            end
                        end
                        est_pkg::KIND_UNSUB: begin
                            n_o_status = est_pkg::ST_NOTFOUND;
                        end
                        default: begin
                            if (r_p_vld) begin
                                n_o_status = est_pkg::ST_DISPATCH;
                                n_o_idx    = r_p_idx;
                                n_o_h      = r_p_h;
                                n_o_u      = r_p_u;
                                n_o_hu     = r_p_hu;
                            end else begin
                                n_o_status = est_pkg::ST_NOSUBS;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = est_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_slot_index   = r_o_idx;
    assign o_out_handler  = r_o_h;
    assign o_out_user     = r_o_u;
    assign o_out_has_user = r_o_hu;
    assign o_last         = r_o_last;

endmodule

### design/event_subscription_table_top.sv
// ----------------------------------------------------------------------------
// event_subscription_table_top
// Subscription table: subscribe, unsubscribe and publish over slot memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_kind, i_event_id, i_handler_tag,
//                                           i_user_tag, i_has_user, i_one_shot
// result    out        o_valid / i_ready    o_status, o_slot_index, o_out_handler,
//                                           o_out_user, o_out_has_user, o_last
//
// One transaction at a time. Subscribe, unsubscribe and publish scan the slot
// memory one slot per cycle while the result register is free, through its
// single read port; a duplicate, a removal or 32 dispatches end a scan early.
// Reserved kinds are accepted, start no scan and give no result.
// Reset clears the valid bits; memory contents are not cleared.
// A held result register stalls the scan until it is taken.
// ----------------------------------------------------------------------------
module event_subscription_table_top #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_event_id,
    input  logic [31:0] i_handler_tag,
    input  logic [31:0] i_user_tag,
    input  logic        i_has_user,
    input  logic        i_one_shot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot_index,
    output logic [31:0] o_out_handler,
    output logic [31:0] o_out_user,
    output logic        o_out_has_user,
    output logic        o_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    est_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    est_pkg::t_entry   wr_data;
    est_pkg::t_entry   rd_data;

    est_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    est_ctrl #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_event_id     (i_event_id),
        .i_handler_tag  (i_handler_tag),
        .i_user_tag     (i_user_tag),
        .i_has_user     (i_has_user),
        .i_one_shot     (i_one_shot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_out_handler  (o_out_handler),
        .o_out_user     (o_out_user),
        .o_out_has_user (o_out_has_user),
        .o_last         (o_last),
        .o_mem_ctl      (mem_ctl),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .i_rd_data      (rd_data)
    );

    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("slot memory read and write in the same cycle");

    a_write_gives_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |=> (o_valid && o_last && o_ready
                           && o_status == est_pkg::ST_ADDED))
        else $error("slot write not followed by an added result");

    a_single_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != est_pkg::ST_DISPATCH)
            |-> (o_last && o_out_handler == 32'd0 && !o_out_has_user))
        else $error("non-dispatch result without last or with payload");

    a_rsvd_kind_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == est_pkg::KIND_RSVD)
            |=> (o_ready && !mem_ctl.wr_en))
        else $error("reserved kind started a scan");

endmodule
